FILE: src/lmst_pkg.sv
// ----------------------------------------------------------------------------
// lmst_pkg: shared constants and types of the local threshold binariser
// Store geometry, register indexes and the word passed along the square
// root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lmst_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_BLOCK = 31;
  localparam int COL_AW    = $clog2(MAX_WIDTH);
  localparam int ROW_SLOTS = 32;
  localparam int SLOT_AW   = $clog2(ROW_SLOTS);
  localparam int ROW_AW    = SLOT_AW + COL_AW;
  localparam int ROW_DEPTH = ROW_SLOTS * MAX_WIDTH;

  // Square root of a 48-bit radicand, one result bit per cell.
  localparam int SQ_STEPS = 24;
  localparam int SQ_RAD_W = 2 * SQ_STEPS;
  localparam int SQ_REM_W = SQ_STEPS + 3;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;
  localparam logic [1:0] REG_K_GAIN       = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_STEPS-1:0] root;
    logic [SQ_RAD_W-1:0] rad;
  } sqrt_stage_t;

endpackage

`default_nettype wire

FILE: src/lmst_ram.sv
// ----------------------------------------------------------------------------
// lmst_ram: generic single write, single read memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/lmst_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lmst_sqrt_cell: one step of a restoring integer square root
// Takes the top two radicand bits, decides one root bit and hands the
// partial remainder and root on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lmst_sqrt_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lmst_pkg::sqrt_stage_t din,
  output lmst_pkg::sqrt_stage_t      dout
);
  import lmst_pkg::*;

  logic [SQ_REM_W-1:0] trial;
  logic [SQ_REM_W-1:0] cand;
  logic                take;

  assign trial = {din.rem[SQ_REM_W-3:0], din.rad[SQ_RAD_W-1 -: 2]};
  assign cand  = {1'b0, din.root, 2'b01};
  assign take  = trial >= cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem  <= take ? trial - cand : trial;
    dout.root <= {din.root[SQ_STEPS-2:0], take};
    dout.rad  <= {din.rad[SQ_RAD_W-3:0], 2'b00};
  end

endmodule

`default_nettype wire

FILE: src/local_mean_stddev_threshold.sv
// ----------------------------------------------------------------------------
// local_mean_stddev_threshold: local mean and deviation binariser
// Line stores and per-column window sums feed a threshold on the local mean
// and standard deviation; each accepted word yields at most one binary word.
// ----------------------------------------------------------------------------
// One input word at a time. Per word: a check and, once the window is
// complete, a refresh of each column sum that enters it (none, one, or up
// to bs/2+1 at the start of a row), the window sum and the arithmetic, part
// of which goes through the square root cell chain. Refresh and window sum
// read the line store and column stores through their single read ports.
// Reset clears positions and control; configuration returns to its defaults
// and no clearing pass runs.
`default_nettype none

module local_mean_stddev_threshold (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // pixel_value [7:0]
  input  wire logic        s_tuser,   // flush_tick [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // binary_pixel [7:0]
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  import lmst_pkg::*;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_CHECK     = 5'd1;
  localparam logic [4:0] ST_FILL      = 5'd2;
  localparam logic [4:0] ST_FILL_WAIT = 5'd3;
  localparam logic [4:0] ST_FILL_WR   = 5'd4;
  localparam logic [4:0] ST_WIN       = 5'd5;
  localparam logic [4:0] ST_WIN_WAIT  = 5'd6;
  localparam logic [4:0] ST_MUL1      = 5'd7;
  localparam logic [4:0] ST_MUL2      = 5'd8;
  localparam logic [4:0] ST_SQ_START  = 5'd9;
  localparam logic [4:0] ST_SQRT      = 5'd10;
  localparam logic [4:0] ST_MUL3      = 5'd11;
  localparam logic [4:0] ST_MUL4      = 5'd12;
  localparam logic [4:0] ST_MUL5      = 5'd13;
  localparam logic [4:0] ST_MUL6      = 5'd14;
  localparam logic [4:0] ST_SUMS      = 5'd15;
  localparam logic [4:0] ST_FINISH    = 5'd16;

  logic [4:0] state;

  // Configuration
  logic [10:0]        image_width;
  logic [11:0]        image_height;
  logic [4:0]         block_size;
  logic signed [14:0] k_gain;

  logic [10:0] w_eff;
  logic [COL_AW-1:0] wm1;
  logic [11:0] h_eff;
  logic [11:0] hm1;
  logic [4:0]  bs;
  logic [4:0]  bsm1;
  logic [3:0]  up;
  logic [4:0]  down;
  logic [9:0]  n;

  assign w_eff = (image_width == 11'd0) ? 11'd1 :
                 (image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width;
  assign wm1   = COL_AW'(w_eff - 11'd1);
  assign h_eff = (image_height == 12'd0) ? 12'd1 : image_height;
  assign hm1   = h_eff - 12'd1;
  assign bs    = (block_size == 5'd0) ? 5'd1 : block_size;
  assign bsm1  = bs - 5'd1;
  assign up    = bs[4:1];
  assign down  = bsm1 - {1'b0, up};
  assign n     = {5'd0, bs} * {5'd0, bs};

  // Positions
  logic [11:0]       in_row;
  logic [COL_AW-1:0] in_col;
  logic [11:0]       out_row;
  logic [COL_AW-1:0] out_col;

  logic s_acc;
  logic store_we;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign store_we = s_acc && !s_tuser && (in_row < h_eff);

  // Window end test
  logic [12:0] nr_raw;
  logic [11:0] nr;
  logic [10:0] nc_raw;
  logic [COL_AW-1:0] nc;
  logic need_ok;
  assign nr_raw  = {1'b0, out_row} + {8'd0, down};
  assign nr      = (nr_raw > {1'b0, hm1}) ? hm1 : nr_raw[11:0];
  assign nc_raw  = {1'b0, out_col} + {6'd0, down};
  assign nc      = (nc_raw > {1'b0, wm1}) ? wm1 : nc_raw[COL_AW-1:0];
  assign need_ok = (in_row > nr) || ((in_row == nr) && (in_col > nc));

  // Column refresh and window walk
  logic [4:0]        dy;
  logic [4:0]        dx;
  logic [COL_AW-1:0] fx;
  logic [COL_AW-1:0] fx_last;
  logic signed [13:0] y_s;
  logic [11:0]        y_cl;
  logic signed [11:0] xx_s;
  logic [COL_AW-1:0]  xx_cl;

  assign y_s  = $signed({2'b00, out_row}) - $signed({10'd0, up}) + $signed({9'd0, dy});
  assign y_cl = (y_s < 0) ? 12'd0 :
                (y_s > $signed({2'b00, hm1})) ? hm1 : y_s[11:0];
  assign xx_s = $signed({2'b00, out_col}) - $signed({8'd0, up}) + $signed({7'd0, dx});
  assign xx_cl = (xx_s < 0) ? '0 :
                 (xx_s > $signed({2'b00, wm1})) ? wm1 : xx_s[COL_AW-1:0];

  // Memories
  logic [ROW_AW-1:0] row_raddr;
  logic [7:0]        row_rdata;
  logic              col_we;
  logic [12:0]       col_s_rdata;
  logic [20:0]       col_q_rdata;
  logic [12:0]       fs;
  logic [20:0]       fq;

  assign row_raddr = (state == ST_FILL) ? {y_cl[SLOT_AW-1:0], fx}
                                        : {out_row[SLOT_AW-1:0], out_col};
  assign col_we    = (state == ST_FILL_WR);

  lmst_ram #(.WIDTH(8), .DEPTH(ROW_DEPTH)) u_row_store (
    .clk   (clk),
    .we    (store_we),
    .waddr ({in_row[SLOT_AW-1:0], in_col}),
    .wdata (s_tdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  lmst_ram #(.WIDTH(13), .DEPTH(MAX_WIDTH)) u_col_sums (
    .clk   (clk),
    .we    (col_we),
    .waddr (fx),
    .wdata (fs),
    .raddr (xx_cl),
    .rdata (col_s_rdata)
  );

  lmst_ram #(.WIDTH(21), .DEPTH(MAX_WIDTH)) u_col_sq_sums (
    .clk   (clk),
    .we    (col_we),
    .waddr (fx),
    .wdata (fq),
    .raddr (xx_cl),
    .rdata (col_q_rdata)
  );

  // Square root cell chain
  sqrt_stage_t sq [SQ_STEPS+1];
  logic [35:0] var_q;

  assign sq[0].valid = (state == ST_SQ_START);
  assign sq[0].rem   = '0;
  assign sq[0].root  = '0;
  assign sq[0].rad   = {var_q, 12'd0};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    lmst_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (sq[i]),
      .dout (sq[i+1])
    );
  end

  // Arithmetic registers
  logic               fill_rd_v;
  logic               win_rd_v;
  logic [17:0]        ws;
  logic [25:0]        wq;
  logic [7:0]         pix;
  logic [35:0]        nq;
  logic [35:0]        ss;
  logic [19:0]        nsq;
  logic signed [26:0] ka;
  logic [SQ_STEPS-1:0] root;
  logic signed [39:0] kb;
  logic [28:0]        lhs;
  logic signed [41:0] xv;
  logic [37:0]        plo;
  logic [36:0]        phi;
  logic [57:0]        nsum;
  logic signed [15:0] kplus;
  logic               res_on;
  logic               out_last;
  logic               out_free;
  logic               fin_go;

  assign kplus    = $signed({k_gain[14], k_gain}) + 16'sd4096;
  // A negative numerator gives a threshold of zero or below; otherwise
  // p >= floor(N/D) is the same as (p+1)*D > N.
  assign res_on   = xv[41] || (58'({lhs, 25'd0}) > nsum);
  assign out_last = (out_row == hm1) && (out_col == wm1);
  assign out_free = !m_tvalid || m_tready;
  assign fin_go   = (state == ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      image_width  <= 11'd640;
      image_height <= 12'd480;
      block_size   <= 5'd15;
      k_gain       <= 15'sd1229;
      in_row       <= '0;
      in_col       <= '0;
      out_row      <= '0;
      out_col      <= '0;
      m_tvalid     <= 1'b0;
      fill_rd_v    <= 1'b0;
      win_rd_v     <= 1'b0;
    end else begin
      fill_rd_v <= (state == ST_FILL);
      win_rd_v  <= (state == ST_WIN);
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[11:0];
          REG_BLOCK_SIZE:   block_size   <= cfg_data[4:0];
          REG_K_GAIN:       k_gain       <= $signed(cfg_data);
          default: ;
        endcase
      end

      // A register write or the last word of the frame restarts both positions.
      if (cfg_we || (fin_go && out_last)) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        if (store_we) begin
          if (in_col == wm1) begin
            in_col <= '0;
            in_row <= in_row + 12'd1;
          end else begin
            in_col <= in_col + COL_AW'(1);
          end
        end
        if (fin_go) begin
          if (out_col == wm1) begin
            out_col <= '0;
            out_row <= out_row + 12'd1;
          end else begin
            out_col <= out_col + COL_AW'(1);
          end
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          dy <= '0;
          dx <= '0;
          if (out_row >= h_eff || !need_ok) begin
            state <= ST_IDLE;
          end else if (out_col == '0) begin
            fx      <= '0;
            fx_last <= ({6'd0, down} > {1'b0, wm1}) ? wm1 : {5'd0, down};
            state   <= ST_FILL;
          end else if (nc_raw <= {1'b0, wm1}) begin
            fx      <= nc_raw[COL_AW-1:0];
            fx_last <= nc_raw[COL_AW-1:0];
            state   <= ST_FILL;
          end else begin
            state <= ST_WIN;
          end
        end
        ST_FILL: begin
          if (dy == bsm1) begin
            state <= ST_FILL_WAIT;
          end else begin
            dy <= dy + 5'd1;
          end
        end
        ST_FILL_WAIT: begin
          state <= ST_FILL_WR;
        end
        ST_FILL_WR: begin
          dy <= '0;
          if (fx == fx_last) begin
            state <= ST_WIN;
          end else begin
            fx    <= fx + COL_AW'(1);
            state <= ST_FILL;
          end
        end
        ST_WIN: begin
          if (dx == bsm1) begin
            state <= ST_WIN_WAIT;
          end else begin
            dx <= dx + 5'd1;
          end
        end
        ST_WIN_WAIT: state <= ST_MUL1;
        ST_MUL1:     state <= ST_MUL2;
        ST_MUL2:     state <= ST_SQ_START;
        ST_SQ_START: state <= ST_SQRT;
        ST_SQRT: begin
          if (sq[SQ_STEPS].valid) begin
            state <= ST_MUL3;
          end
        end
        ST_MUL3:  state <= ST_MUL4;
        ST_MUL4:  state <= ST_MUL5;
        ST_MUL5:  state <= ST_MUL6;
        ST_MUL6:  state <= ST_SUMS;
        ST_SUMS:  state <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    if (state == ST_CHECK || state == ST_FILL_WR) begin
      fs <= '0;
      fq <= '0;
    end else if (fill_rd_v) begin
      fs <= fs + {5'd0, row_rdata};
      fq <= fq + {5'd0, {8'd0, row_rdata} * {8'd0, row_rdata}};
    end

    if (state == ST_CHECK || state == ST_FILL_WR) begin
      ws <= '0;
      wq <= '0;
    end else if (win_rd_v) begin
      ws <= ws + {5'd0, col_s_rdata};
      wq <= wq + {5'd0, col_q_rdata};
    end

    if (state == ST_MUL1) begin
      pix <= row_rdata;
      nq  <= n * wq;
      ss  <= ws * ws;
    end
    if (state == ST_MUL2) begin
      var_q <= (nq >= ss) ? nq - ss : '0;
      nsq   <= n * n;
      ka    <= kplus * $signed({1'b0, n});
    end
    if (state == ST_SQRT && sq[SQ_STEPS].valid) begin
      root <= sq[SQ_STEPS].root;
    end
    if (state == ST_MUL3) begin
      kb  <= k_gain * $signed({1'b0, root});
      lhs <= ({1'b0, pix} + 9'd1) * nsq;
    end
    if (state == ST_MUL4) begin
      xv <= (42'(ka) <<< 13) - 42'(kb);
    end
    if (state == ST_MUL5) begin
      plo <= ws * xv[19:0];
    end
    if (state == ST_MUL6) begin
      phi <= ws * xv[38:20];
    end
    if (state == ST_SUMS) begin
      nsum <= 58'(plo) + (58'(phi) << 20);
    end
    if (fin_go) begin
      m_tdata <= res_on ? 8'hFF : 8'h00;
      m_tlast <= out_last;
    end
  end

  // Checks
  a_in_ahead: assert property (@(posedge clk) disable iff (rst)
    in_row >= out_row)
    else $error("input row fell behind the output row");

  a_fill_rd: assert property (@(posedge clk) disable iff (rst)
    fill_rd_v |-> (state == ST_FILL || state == ST_FILL_WAIT))
    else $error("line store read returned outside a column refresh");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sq[SQ_STEPS].valid |-> state == ST_SQRT)
    else $error("square root result arrived outside its wait state");

  a_hold_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && m_tvalid && !m_tready) |=> state == ST_FINISH)
    else $error("result overwrote a word still waiting");

  a_binary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'hFF || m_tdata == 8'h00))
    else $error("output word not binary");

endmodule

`default_nettype wire

FILE: dv/local_mean_stddev_threshold_tb.sv
// ----------------------------------------------------------------------------
// local_mean_stddev_threshold_tb: self-checking bench of the local binariser
// Streams grey frames through the block under window, frame and gain settings,
// takes each binary word from a directed table or an exact integer model of
// the local mean and deviation threshold, and compares the output with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_mean_stddev_threshold_tb;
  import lmst_pkg::*;

  localparam int SETTLE = 800;  // extra idle wait after the last expected word

  typedef struct packed {
    logic [7:0] bin;
    logic       last;
  } bin_word_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [14:0] val;
    logic [7:0]  pix;
    logic        fl;
    logic        typed;
    logic        got;
    logic [7:0]  bin;
    logic        last;
  } dir_row_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [7:0]  s_tdata;
  logic        m_tvalid, m_tready, m_tlast;
  logic [7:0]  m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  local_mean_stddev_threshold i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we, .cfg_index, .cfg_data
  );

  // Predictor state.
  logic [10:0]        reg_w;
  logic [11:0]        reg_h;
  logic [4:0]         reg_bs;
  logic signed [14:0] reg_k;
  logic [7:0]         line_mem [ROW_SLOTS*MAX_WIDTH];
  int unsigned        col_sum [MAX_WIDTH];
  int unsigned        col_sq [MAX_WIDTH];
  int                 in_pos, out_pos;
  bit                 frame_end_seen;

  bin_word_t pending_bins[$];
  int  n_items, n_bins, n_errors, n_frames, n_phases;
  int  send_idle_pct, recv_idle_pct, hold_left;
  bit  use_typed;
  bin_word_t typed_word;
  bit  typed_got;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("local_mean_stddev_threshold test failed");
    $finish;
  end

  function automatic int eff_w();
    return reg_w == 0 ? 1 : (reg_w > MAX_WIDTH ? MAX_WIDTH : int'(reg_w));
  endfunction

  function automatic int eff_h();
    return reg_h == 0 ? 1 : int'(reg_h);
  endfunction

  function automatic int eff_bs();
    return reg_bs == 0 ? 1 : (reg_bs > MAX_BLOCK ? MAX_BLOCK : int'(reg_bs));
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Refreshes the vertical window sums of one column for output row r.
  task automatic col_fill(int r, int x, int h, int up, int bs);
    int unsigned s, q, p;
    int y;
    s = 0;
    q = 0;
    for (int dy = 0; dy < bs; dy++) begin
      y = r - up + dy;
      if (y < 0) y = 0;
      if (y > h - 1) y = h - 1;
      p = line_mem[(y % ROW_SLOTS) * MAX_WIDTH + x % MAX_WIDTH];
      s += p;
      q += p * p;
    end
    col_sum[x % MAX_WIDTH] = s;
    col_sq[x % MAX_WIDTH] = q;
  endtask

  task automatic threshold_step(input logic [7:0] pix, input logic fl, output bit got,
                                output bin_word_t res);
    int w, h, bs, tot, r, c, up, dn, nr, nc, xx, n;
    longint unsigned s, q, v, root;
    longint num, den, thr, kk;
    got = 0;
    res = '0;
    s = 0;
    q = 0;
    w = eff_w();
    h = eff_h();
    bs = eff_bs();
    tot = w * h;
    up = bs / 2;
    dn = bs - 1 - up;
    if (!fl && in_pos < tot) begin
      line_mem[((in_pos / w) % ROW_SLOTS) * MAX_WIDTH + in_pos % w] = pix;
      in_pos++;
    end
    if (out_pos >= tot) return;
    r = out_pos / w;
    c = out_pos % w;
    nr = (r + dn > h - 1) ? h - 1 : r + dn;
    nc = (c + dn > w - 1) ? w - 1 : c + dn;
    if (in_pos <= nr * w + nc) return;
    if (c == 0) begin
      for (int x = 0; x <= (dn < w - 1 ? dn : w - 1); x++) col_fill(r, x, h, up, bs);
    end else if (c + dn <= w - 1) begin
      col_fill(r, c + dn, h, up, bs);
    end
    for (int dx = -up; dx <= dn; dx++) begin
      xx = c + dx;
      if (xx < 0) xx = 0;
      if (xx > w - 1) xx = w - 1;
      s += col_sum[xx];
      q += col_sq[xx];
    end
    n = bs * bs;
    v = longint'(n) * q;
    v = (v >= s * s) ? v - s * s : 0;
    root = isqrt(v << 12);
    kk = longint'(reg_k);
    num = longint'(s) * ((4096 + kk) * 8192 * n - kk * longint'(root));
    den = longint'(n) * n * 33554432;
    thr = num / den;
    got = 1;
    res.bin = (longint'(line_mem[(r % ROW_SLOTS) * MAX_WIDTH + c]) >= thr) ? 8'd255 : 8'd0;
    out_pos++;
    res.last = (out_pos == tot);
    if (out_pos == tot) begin
      in_pos = 0;
      out_pos = 0;
      frame_end_seen = 1;
    end
  endtask

  // Input acceptance feeds the predictor; output acceptance is checked.
  always @(posedge clk) begin
    bit got;
    bin_word_t res, seen, want;
    if (!rst && s_tvalid && s_tready) begin
      n_items++;
      threshold_step(s_tdata, s_tuser, got, res);
      if (use_typed) begin
        got = typed_got;
        res = typed_word;
      end
      if (got) pending_bins.push_back(res);
    end
    if (!rst && m_tvalid && m_tready) begin
      seen = '{bin: m_tdata, last: m_tlast};
      n_bins++;
      if (seen.last) n_frames++;
      if (pending_bins.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word: bin=%0d last=%0b", seen.bin, seen.last);
      end else begin
        want = pending_bins.pop_front();
        if (seen.bin !== want.bin || seen.last !== want.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("word %0d mismatch: bin exp %0d got %0d, last exp %0b got %0b",
                     n_bins, want.bin, seen.bin, want.last, seen.last);
        end
      end
    end
  end

  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [7:0] p, input logic fl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    s_tuser <= fl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_bins.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  reg_w = val[10:0];
      REG_IMAGE_HEIGHT: reg_h = val[11:0];
      REG_BLOCK_SIZE:   reg_bs = val[4:0];
      REG_K_GAIN:       reg_k = val;
      default: ;
    endcase
    // Any register write abandons the frame in progress.
    in_pos = 0;
    out_pos = 0;
    @(negedge clk);
  endtask

  // Drives one frame, choosing each word from the predicted frame position;
  // a non-zero cut stops the frame early so that a register write aborts it.
  task automatic run_frame(int mode, int cut);
    int base, tot;
    logic [7:0] p;
    frame_end_seen = 0;
    base = $urandom_range(255);
    tot = eff_w() * eff_h();
    while (!frame_end_seen && !(cut > 0 && in_pos >= cut)) begin
      case (mode)
        0: p = 8'($urandom_range(255));
        1: p = (base + $urandom_range(16) < 8) ? 8'd0 :
               (base + $urandom_range(16) - 8 > 255 ? 8'd255 : 8'(base + $urandom_range(16) - 8));
        default: p = $urandom_range(1) ? 8'd255 : 8'd0;
      endcase
      if (in_pos < tot) begin
        if ($urandom_range(99) < 3) send_word(8'($urandom_range(255)), 1'b1);
        else send_word(p, 1'b0);
      end else begin
        if ($urandom_range(99) < 5) send_word(p, 1'b0);
        else send_word(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  dir_row_t dir_tab [] = '{
    '{1, REG_IMAGE_WIDTH,  15'd4,     0,   0, 0, 0, 0,   0},
    '{1, REG_IMAGE_HEIGHT, 15'd2,     0,   0, 0, 0, 0,   0},
    '{1, REG_BLOCK_SIZE,   15'd1,     0,   0, 0, 0, 0,   0},
    '{1, REG_K_GAIN,       15'd0,     0,   0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd0,   0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd255, 0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd1,   0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd128, 0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd77,  1, 1, 0, 0,   0},
    '{0, 0, 0, 8'd7,   0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd200, 0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd3,   0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd9,   0, 1, 1, 255, 1},
    '{1, REG_K_GAIN,       15'h3FFF,  0,   0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd0,   0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd1,   0, 1, 1, 0,   0},
    '{0, 0, 0, 8'd255, 0, 1, 1, 0,   0},
    '{0, 0, 0, 8'd2,   0, 1, 1, 0,   0},
    '{0, 0, 0, 8'd0,   0, 1, 1, 255, 0},
    '{0, 0, 0, 8'd255, 0, 1, 1, 0,   0},
    '{0, 0, 0, 8'd3,   0, 1, 1, 0,   0},
    '{0, 0, 0, 8'd0,   0, 1, 1, 255, 1},
    '{1, REG_K_GAIN,       15'h4000,  0,   0, 0, 0, 0,   0},
    '{1, REG_BLOCK_SIZE,   15'd3,     0,   0, 0, 0, 0,   0},
    '{1, REG_IMAGE_WIDTH,  15'd3,     0,   0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd10,  0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd250, 0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd30,  0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd40,  0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd255, 0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd0,   0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd99,  0, 0, 0, 0,   0},
    '{0, 0, 0, 8'd5,   1, 0, 0, 0,   0},
    '{0, 0, 0, 8'd6,   1, 0, 0, 0,   0}
  };

  initial begin
    int w, h, bs, k, cut, sel;
    bit held;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    cfg_we = 0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = 0;
    reg_w = 640;
    reg_h = 480;
    reg_bs = 15;
    reg_k = 1229;
    in_pos = 0;
    out_pos = 0;
    foreach (col_sum[i]) begin
      col_sum[i] = 0;
      col_sq[i] = 0;
    end
    n_items = 0; n_bins = 0; n_errors = 0; n_frames = 0; n_phases = 0;
    send_idle_pct = 10;
    recv_idle_pct = 47;
    hold_left = 0;
    use_typed = 0;
    held = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        cfg_write(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        use_typed = dir_tab[i].typed;
        typed_got = dir_tab[i].got;
        typed_word = '{bin: dir_tab[i].bin, last: dir_tab[i].last};
        send_word(dir_tab[i].pix, dir_tab[i].fl);
      end
    end
    use_typed = 0;

    while (n_items < 1750) begin
      if (n_items < 600) begin
        send_idle_pct = 10; recv_idle_pct = 47;
      end else if (n_items < 1200) begin
        send_idle_pct = 47; recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      bs = $urandom_range(1, 7);
      k = $urandom_range(32767);
      cut = ($urandom_range(19) == 0) ? $urandom_range(1, 20) : 0;
      sel = $urandom_range(15);
      case (sel)
        0: begin w = 0; h = 0; bs = 0; end
        1: begin w = 5; h = 6; bs = 30; end
        2: begin w = 3; h = 34; bs = 31; end
        3: begin w = 2047; h = 4095; bs = 1; cut = 40; end
        4: begin w = 1024; h = 4095; bs = 31; cut = 40; end
        5: k = $urandom_range(1) ? 16383 : 16384;
        6: bs = $urandom_range(8, 12);
        default: ;
      endcase
      n_phases++;
      wait_idle();
      cfg_write(REG_IMAGE_WIDTH, 15'(w));
      cfg_write(REG_IMAGE_HEIGHT, 15'(h));
      cfg_write(REG_BLOCK_SIZE, 15'(bs));
      cfg_write(REG_K_GAIN, 15'(k));
      // Once, with no idling, the receiver stalls long enough to back up the input.
      if (!held && recv_idle_pct == 0 && cut == 0) begin
        held = 1;
        hold_left = 600;
      end
      if (cut > 0) begin
        run_frame($urandom_range(2), cut);
      end else begin
        repeat ($urandom_range(1, 3)) run_frame($urandom_range(2), 0);
      end
    end

    wait_idle();
    $display("Covered %0d input words and %0d binary words in %0d frames,", n_items, n_bins,
             n_frames);
    $display("over %0d register settings including out-of-range and extreme values.",
             n_phases);
    if (n_errors == 0) begin
      $display("local_mean_stddev_threshold test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("local_mean_stddev_threshold test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/lmst_pkg.sv
src/lmst_ram.sv
src/lmst_sqrt_cell.sv
src/local_mean_stddev_threshold.sv
dv/local_mean_stddev_threshold_tb.sv
